### hdl/hbw_pkg.sv
`default_nettype none

package hbw_pkg;

    localparam int DEF_NUM_CHANNELS = 16;
    localparam int DEF_TIME_WIDTH   = 32;

    localparam int REQ_W     = 2;
    localparam int CH_W      = 4;
    localparam int NOW_W     = 32;
    localparam int TIMEOUT_W = 32;
    localparam int BEAT_W    = 32;
    localparam int REGS_W    = 5;
    localparam int MASK_W    = 16;

    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 32'd1000;
    localparam logic [BEAT_W-1:0]    BEAT_MAX      = '1;
    localparam logic [REGS_W-1:0]    REGS_MAX      = '1;

    typedef enum logic [REQ_W-1:0] {
        REQ_REGISTER  = 2'd0,
        REQ_HEARTBEAT = 2'd1,
        REQ_CHECK     = 2'd2,
        REQ_QUERY     = 2'd3
    } req_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_MODIFY,
        ST_FETCH,
        ST_REPORT
    } state_t;

    typedef struct packed {
        logic [REQ_W-1:0] req_type;
        logic [CH_W-1:0]  channel;
        logic [NOW_W-1:0] now_ms;
    } item_t;

    typedef struct packed {
        logic              newly_failed;
        logic              channel_healthy;
        logic [BEAT_W-1:0] beat_total;
        logic [REGS_W-1:0] registered_total;
        logic [MASK_W-1:0] unhealthy_mask;
    } result_t;

endpackage

`default_nettype wire

### hdl/hbw_ram.sv
`default_nettype none

module hbw_ram
    import hbw_pkg::*;
#(
    parameter int DEPTH  = DEF_NUM_CHANNELS,
    parameter int ADDR_W = 4,
    parameter int DATA_W = DEF_TIME_WIDTH + BEAT_W
)
(
    input  wire logic              clk,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [DATA_W-1:0] rd_data,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [DATA_W-1:0] wr_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

### hdl/multi_channel_heartbeat_watchdog.sv
`default_nettype none

// Heartbeat watchdog over NUM_CHANNELS channels.
// Command channel: item is taken on a rising edge with start high and busy
// low. Request types: register, heartbeat, check sweep, status query.
// Result: done is high for one cycle with result valid; it cannot be held off.
// Steps from accept to done through the channel table memory, which is read
// one entry per cycle in a sweep:
//   register / heartbeat (channel in table): read, write, re-read, report
//   status query or channel out of table:    read, report
//   check sweep:                             sweep read of every entry,
//                                             re-read, report
// busy is high from accept until the cycle of done; the next item may be
// started in the done cycle.
// Configuration: cfg_valid/cfg_ready write the timeout; cfg_ready is always
// high; the user must make writes only while no item is in flight (unchecked).
// Reset: all channels unregistered, timeout 1000, no result pending. The
// table memory is not cleared; entries are written when a channel is first
// registered.
module multi_channel_heartbeat_watchdog
    import hbw_pkg::*;
#(
    parameter int NUM_CHANNELS = DEF_NUM_CHANNELS,
    parameter int TIME_WIDTH   = DEF_TIME_WIDTH
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire item_t                item,
    output logic                      done,
    output result_t                   result,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [TIMEOUT_W-1:0] cfg_data
);

    localparam int IDX_W   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int CNT_W   = $clog2(NUM_CHANNELS + 1);
    localparam int CMP_W   = (TIME_WIDTH > TIMEOUT_W) ? TIME_WIDTH : TIMEOUT_W;
    localparam int PAD_W   = (NUM_CHANNELS > MASK_W) ? NUM_CHANNELS : MASK_W;
    localparam int ENT_W   = TIME_WIDTH + BEAT_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_CHANNELS - 1);

    state_t                  state_reg, state_next;
    req_t                    req_reg;
    logic [CH_W-1:0]         ch_reg;
    logic [TIME_WIDTH-1:0]   now_reg;
    logic [IDX_W-1:0]        idx_reg;
    logic                    cmp_vld_reg;
    logic [IDX_W-1:0]        cmp_idx_reg;
    logic                    failed_reg;
    logic [NUM_CHANNELS-1:0] valid_reg;
    logic [NUM_CHANNELS-1:0] health_reg;
    logic [CNT_W-1:0]        reg_cnt_reg;
    logic [TIMEOUT_W-1:0]    timeout_reg;
    logic                    done_reg;
    result_t                 result_reg;

    logic                    rd_en;
    logic [IDX_W-1:0]        rd_addr;
    logic [ENT_W-1:0]        rd_data;
    logic                    wr_en;
    logic [ENT_W-1:0]        wr_data;

    logic                    accept;
    logic                    item_in_table;
    logic                    in_table;
    logic [IDX_W-1:0]        ch_idx;
    logic [TIME_WIDTH-1:0]   rd_time;
    logic [BEAT_W-1:0]       rd_beat;
    logic [TIME_WIDTH-1:0]   elapsed;
    logic                    timed_out;
    logic                    ch_valid;
    logic [BEAT_W-1:0]       old_beat;
    logic [BEAT_W-1:0]       new_beat;
    logic [PAD_W-1:0]        mask_pad;

    assign accept        = start && !busy;
    assign item_in_table = int'(item.channel) < NUM_CHANNELS;
    assign in_table      = int'(ch_reg) < NUM_CHANNELS;
    assign ch_idx        = IDX_W'(ch_reg);
    assign ch_valid      = in_table && valid_reg[ch_idx];

    assign rd_time   = rd_data[ENT_W-1 -: TIME_WIDTH];
    assign rd_beat   = rd_data[BEAT_W-1:0];
    assign elapsed   = now_reg - rd_time;
    assign timed_out = CMP_W'(elapsed) > CMP_W'(timeout_reg);

    assign old_beat = valid_reg[ch_idx] ? rd_beat : '0;
    assign new_beat = (req_reg == REQ_REGISTER) ? '0 :
                      (old_beat == BEAT_MAX)    ? old_beat : old_beat + 1'b1;
    assign wr_data  = {now_reg, new_beat};
    assign mask_pad = PAD_W'(valid_reg & ~health_reg);

    assign busy      = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;
    assign done      = done_reg;
    assign result    = result_reg;

    hbw_ram #(
        .DEPTH  (NUM_CHANNELS),
        .ADDR_W (IDX_W),
        .DATA_W (ENT_W)
    ) u_ram (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (ch_idx),
        .wr_data (wr_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        rd_en      = 1'b0;
        rd_addr    = IDX_W'(item.channel);
        wr_en      = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    rd_en = 1'b1;
                    unique case (req_t'(item.req_type)) inside
                        REQ_REGISTER, REQ_HEARTBEAT:
                        begin
                            state_next = item_in_table ? ST_MODIFY : ST_REPORT;
                        end
                        REQ_CHECK:
                        begin
                            state_next = ST_SWEEP;
                        end
                        default:
                        begin
                            state_next = ST_REPORT;
                        end
                    endcase
                end
            end
            ST_SWEEP:
            begin
                rd_en   = 1'b1;
                rd_addr = idx_reg;
                if (idx_reg == LAST_IDX)
                begin
                    state_next = ST_FETCH;
                end
            end
            ST_MODIFY:
            begin
                wr_en      = 1'b1;
                state_next = ST_FETCH;
            end
            ST_FETCH:
            begin
                rd_en      = 1'b1;
                rd_addr    = ch_idx;
                state_next = ST_REPORT;
            end
            ST_REPORT:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmp_vld_reg <= 1'b0;
            failed_reg  <= 1'b0;
            valid_reg   <= '0;
            reg_cnt_reg <= '0;
            timeout_reg <= TIMEOUT_RESET;
            done_reg    <= 1'b0;
        end
        else
        begin
            cmp_vld_reg <= (state_reg == ST_SWEEP);
            done_reg    <= (state_reg == ST_REPORT);
            if (cfg_valid && cfg_ready)
            begin
                timeout_reg <= cfg_data;
            end
            if (accept)
            begin
                failed_reg <= 1'b0;
            end
            else if (cmp_vld_reg && valid_reg[cmp_idx_reg] && timed_out
                     && health_reg[cmp_idx_reg])
            begin
                failed_reg <= 1'b1;
            end
            if (state_reg == ST_MODIFY && !valid_reg[ch_idx])
            begin
                valid_reg[ch_idx] <= 1'b1;
                reg_cnt_reg       <= reg_cnt_reg + 1'b1;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= req_t'(item.req_type);
            ch_reg  <= item.channel;
            now_reg <= TIME_WIDTH'(item.now_ms);
            idx_reg <= '0;
        end
        else if (state_reg == ST_SWEEP)
        begin
            idx_reg <= idx_reg + 1'b1;
        end
        cmp_idx_reg <= idx_reg;
        if (state_reg == ST_MODIFY)
        begin
            health_reg[ch_idx] <= 1'b1;
        end
        else if (cmp_vld_reg && valid_reg[cmp_idx_reg])
        begin
            health_reg[cmp_idx_reg] <= !timed_out;
        end
        if (state_reg == ST_REPORT)
        begin
            result_reg.newly_failed     <= failed_reg;
            result_reg.channel_healthy  <= ch_valid && health_reg[ch_idx];
            result_reg.beat_total       <= ch_valid ? rd_beat : '0;
            result_reg.registered_total <= (reg_cnt_reg > CNT_W'(REGS_MAX) ||
                                            CNT_W > REGS_W && reg_cnt_reg >= 31)
                                           ? REGS_MAX : REGS_W'(reg_cnt_reg);
            result_reg.unhealthy_mask   <= mask_pad[MASK_W-1:0];
        end
    end

    a_done_after_report: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg == ST_REPORT))
        else $error("done without report");

    a_reg_count: assert property (@(posedge clk) disable iff (!rst_n)
        int'(reg_cnt_reg) == $countones(valid_reg))
        else $error("registered count out of step with valid bits");

    a_cmp_window: assert property (@(posedge clk) disable iff (!rst_n)
        cmp_vld_reg |-> (state_reg == ST_SWEEP || state_reg == ST_FETCH))
        else $error("sweep compare outside sweep");

    a_fail_only_check: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && result_reg.newly_failed |-> req_reg == REQ_CHECK)
        else $error("new failure reported for non-check request");

    a_no_write_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> !cmp_vld_reg)
        else $error("table write during sweep");

endmodule

`default_nettype wire
